FILE: rtl/core/gps_pkg.sv
`default_nettype none
package gps_pkg;

  localparam int NUM_LEG_PORTS   = 4;
  localparam int DEF_LEGS        = 4;
  localparam int DEF_MAX_HORIZON = 64;

  localparam int PHASE_W   = 16;
  localparam int SCALE_W   = 24;
  localparam int PROD_W    = PHASE_W + SCALE_W;
  localparam int CONTACT_W = 2;
  localparam int ROW_IDX_W = 6;
  localparam int HLEN_W    = 7;
  localparam int OFFS_W    = NUM_LEG_PORTS * PHASE_W;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TICK_STEP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HORIZON_STEP = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STANCE_SCALE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SWING_SCALE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LEG_OFFSETS  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_HORIZON_LEN  = 3'd6;

  localparam logic [PHASE_W-1:0] RST_TICK_STEP    = 16'd66;
  localparam logic [PHASE_W-1:0] RST_HORIZON_STEP = 16'd1311;
  localparam logic [PHASE_W-1:0] RST_DUTY         = 16'd32768;
  localparam logic [SCALE_W-1:0] RST_STANCE_SCALE = 24'd131072;
  localparam logic [SCALE_W-1:0] RST_SWING_SCALE  = 24'd131072;
  localparam logic [OFFS_W-1:0]  RST_LEG_OFFSETS  = '0;
  localparam logic [HLEN_W-1:0]  RST_HORIZON_LEN  = 7'd10;

  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_TABLE = 1'b1;

  localparam logic [CONTACT_W-1:0] CONTACT_STANCE = 2'd0;
  localparam logic [CONTACT_W-1:0] CONTACT_SWING  = 2'd1;
  localparam logic [CONTACT_W-1:0] CONTACT_EARLY  = 2'd2;
  localparam logic [CONTACT_W-1:0] CONTACT_LATE   = 2'd3;

  localparam logic LEG_STANCE = 1'b0;
  localparam logic LEG_SWING  = 1'b1;

  typedef struct packed {
    logic cmp_en;     // tick: latch compare and operand select
    logic mul_en;     // tick: latch product
    logic commit;     // update leg state this cycle
    logic is_row;     // table row, else tick
    logic row_first;  // first table row
    logic standing;
  } gps_lane_ctl_t;

  typedef struct packed {
    logic [NUM_LEG_PORTS-1:0]              state;
    logic [NUM_LEG_PORTS-1:0][PHASE_W-1:0] phase;
    logic [ROW_IDX_W-1:0]                  row_index;
    logic                                  last;
  } gps_row_t;

endpackage
`default_nettype wire

FILE: rtl/core/gps_if.sv
`default_nettype none
interface gps_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic        standing;
  logic [15:0] start_phase;
  logic [1:0]  contact_leg0;
  logic [1:0]  contact_leg1;
  logic [1:0]  contact_leg2;
  logic [1:0]  contact_leg3;
  logic [3:0]  active_mask;

  modport source (
    output valid, command, standing, start_phase,
           contact_leg0, contact_leg1, contact_leg2, contact_leg3, active_mask,
    input  ready
  );
  modport sink (
    input  valid, command, standing, start_phase,
           contact_leg0, contact_leg1, contact_leg2, contact_leg3, active_mask,
    output ready
  );
endinterface

interface gps_out_if;
  logic        valid;
  logic        ready;
  logic        state_leg0;
  logic        state_leg1;
  logic        state_leg2;
  logic        state_leg3;
  logic [15:0] phase_leg0;
  logic [15:0] phase_leg1;
  logic [15:0] phase_leg2;
  logic [15:0] phase_leg3;
  logic [5:0]  row_index;
  logic        last;

  modport source (
    output valid, state_leg0, state_leg1, state_leg2, state_leg3,
           phase_leg0, phase_leg1, phase_leg2, phase_leg3, row_index, last,
    input  ready
  );
  modport sink (
    input  valid, state_leg0, state_leg1, state_leg2, state_leg3,
           phase_leg0, phase_leg1, phase_leg2, phase_leg3, row_index, last,
    output ready
  );
endinterface
`default_nettype wire

FILE: rtl/core/gps_lane.sv
`default_nettype none
module gps_lane (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire gps_pkg::gps_lane_ctl_t          ctl,
  input  wire logic [gps_pkg::PHASE_W-1:0]     base_phase,
  input  wire logic [gps_pkg::PHASE_W-1:0]     offset,
  input  wire logic [gps_pkg::PHASE_W-1:0]     duty,
  input  wire logic [gps_pkg::SCALE_W-1:0]     stance_scale,
  input  wire logic [gps_pkg::SCALE_W-1:0]     swing_scale,
  input  wire logic [gps_pkg::CONTACT_W-1:0]   contact,
  input  wire logic                            active,
  output logic                                 emit_state,
  output logic [gps_pkg::PHASE_W-1:0]          emit_phase
);

  logic [gps_pkg::PHASE_W-1:0] p;
  logic                        p_lt;

  logic                        lt_r;
  logic [gps_pkg::PHASE_W-1:0] frac_r;
  logic [gps_pkg::SCALE_W-1:0] scale_r;
  logic [gps_pkg::PROD_W-1:0]  prod_r;

  logic                        tick_state_r, tick_state_nxt;
  logic [gps_pkg::PHASE_W-1:0] tick_phase_r, tick_phase_nxt;
  logic                        tbl_state_r, tbl_state_nxt;
  logic [gps_pkg::PHASE_W-1:0] sat_phase;

  assign p    = base_phase + offset;
  assign p_lt = (p < duty);

  // truncate Q8.32 product back to Q0.16 and clip
  assign sat_phase = (|prod_r[gps_pkg::PROD_W-1:32]) ? {gps_pkg::PHASE_W{1'b1}}
                                                     : prod_r[31:16];

  always_comb begin
    if (lt_r) begin
      tick_state_nxt = gps_pkg::LEG_STANCE;
    end else if (ctl.standing) begin
      tick_state_nxt = tick_state_r;
    end else begin
      tick_state_nxt = gps_pkg::LEG_SWING;
    end
    tick_phase_nxt = (lt_r && ctl.standing) ? tick_phase_r : sat_phase;
  end

  always_comb begin
    tbl_state_nxt = tbl_state_r;
    if (ctl.standing) begin
      if (p_lt && (contact != gps_pkg::CONTACT_SWING)) begin
        tbl_state_nxt = gps_pkg::LEG_STANCE;
      end
    end else begin
      tbl_state_nxt = p_lt ? gps_pkg::LEG_STANCE : gps_pkg::LEG_SWING;
    end
    if (contact == gps_pkg::CONTACT_EARLY) begin
      tbl_state_nxt = gps_pkg::LEG_STANCE;
    end
    if (ctl.row_first && (contact == gps_pkg::CONTACT_LATE)) begin
      tbl_state_nxt = gps_pkg::LEG_SWING;
    end
  end

  always_comb begin
    if (ctl.is_row) begin
      emit_state = active ? tbl_state_nxt : gps_pkg::LEG_SWING;
      emit_phase = '0;
    end else begin
      emit_state = tick_state_nxt;
      emit_phase = tick_phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.cmp_en) begin
      lt_r    <= p_lt;
      frac_r  <= p_lt ? p : (p - duty);
      scale_r <= p_lt ? stance_scale : swing_scale;
    end
    if (ctl.mul_en) begin
      prod_r <= gps_pkg::PROD_W'(frac_r) * gps_pkg::PROD_W'(scale_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_state_r <= gps_pkg::LEG_STANCE;
      tick_phase_r <= '0;
      tbl_state_r  <= gps_pkg::LEG_STANCE;
    end else if (ctl.commit) begin
      if (ctl.is_row) begin
        if (active) begin
          tbl_state_r <= tbl_state_nxt;
        end
      end else begin
        tick_state_r <= tick_state_nxt;
        tick_phase_r <= tick_phase_nxt;
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/gps_merge.sv
`default_nettype none
module gps_merge (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load,
  input  wire gps_pkg::gps_row_t row,
  output logic                   slot_free,
  gps_out_if.source              out_ch
);

  gps_pkg::gps_row_t row_r;
  logic              valid_r;

  assign slot_free = !valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      row_r <= row;
    end
  end

  assign out_ch.valid      = valid_r;
  assign out_ch.state_leg0 = row_r.state[0];
  assign out_ch.state_leg1 = row_r.state[1];
  assign out_ch.state_leg2 = row_r.state[2];
  assign out_ch.state_leg3 = row_r.state[3];
  assign out_ch.phase_leg0 = row_r.phase[0];
  assign out_ch.phase_leg1 = row_r.phase[1];
  assign out_ch.phase_leg2 = row_r.phase[2];
  assign out_ch.phase_leg3 = row_r.phase[3];
  assign out_ch.row_index  = row_r.row_index;
  assign out_ch.last       = row_r.last;

endmodule
`default_nettype wire

FILE: rtl/core/gait_phase_scheduler_core.sv
// Tick: the request passes through compare, multiply and commit states; the result is
// loaded into the output register once it has room, and the next input is taken after that.
// Table: one row per cycle in the row state after accept, paced by the output register;
// a new request waits for the last row. Each leg has its own lane and multiplier.
// Reset (rst_n low, synchronous): config returns to defaults, phases, leg states
// and handshake state clear.
`default_nettype none
module gait_phase_scheduler_core #(
  parameter int LEGS        = gps_pkg::DEF_LEGS,
  parameter int MAX_HORIZON = gps_pkg::DEF_MAX_HORIZON
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [gps_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [gps_pkg::CFG_DATA_W-1:0]    cfg_data,
  gps_in_if.sink                                 in_ch,
  gps_out_if.source                              out_ch
);

  localparam int ROW_W = (MAX_HORIZON > 1) ? $clog2(MAX_HORIZON) : 1;

  typedef enum logic [2:0] {S_IDLE, S_TICK_CMP, S_TICK_MUL, S_TICK_OUT, S_ROW} state_t;

  state_t state_r;

  logic [gps_pkg::PHASE_W-1:0] tick_step_r;
  logic [gps_pkg::PHASE_W-1:0] hor_step_r;
  logic [gps_pkg::PHASE_W-1:0] duty_r;
  logic [gps_pkg::SCALE_W-1:0] stance_scale_r;
  logic [gps_pkg::SCALE_W-1:0] swing_scale_r;
  logic [gps_pkg::OFFS_W-1:0]  offsets_r;
  logic [gps_pkg::HLEN_W-1:0]  hor_len_r;

  logic [gps_pkg::PHASE_W-1:0] run_phase_r;
  logic                        prev_standing_r;
  logic [gps_pkg::PHASE_W-1:0] tbl_phase_r, tbl_phase_nxt;
  logic [ROW_W-1:0]            row_cnt_r;
  logic [ROW_W-1:0]            last_idx_r, last_idx_nxt;
  logic                        standing_r;
  logic [gps_pkg::NUM_LEG_PORTS-1:0][gps_pkg::CONTACT_W-1:0] contact_r;
  logic [gps_pkg::NUM_LEG_PORTS-1:0] mask_r;

  logic                        accept;
  logic                        slot_free;
  logic                        load;
  logic                        row_last;
  logic [gps_pkg::PHASE_W-1:0] base_phase;
  logic [gps_pkg::PHASE_W-1:0] run_start;
  gps_pkg::gps_lane_ctl_t      lane_ctl;
  gps_pkg::gps_row_t           row;
  logic [gps_pkg::NUM_LEG_PORTS-1:0]                     lane_state;
  logic [gps_pkg::NUM_LEG_PORTS-1:0][gps_pkg::PHASE_W-1:0] lane_phase;

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  assign tbl_phase_nxt = tbl_phase_r + hor_step_r;
  assign base_phase    = (state_r == S_ROW) ? tbl_phase_nxt : run_phase_r;
  assign row_last      = (row_cnt_r == last_idx_r);
  assign load          = slot_free && ((state_r == S_TICK_OUT) || (state_r == S_ROW));
  assign run_start     = (prev_standing_r && !in_ch.standing) ? '0 : run_phase_r;

  // zero rows acts as one, anything past the horizon depth is clipped
  always_comb begin
    if (hor_len_r == '0) begin
      last_idx_nxt = '0;
    end else if (hor_len_r > gps_pkg::HLEN_W'(MAX_HORIZON)) begin
      last_idx_nxt = ROW_W'(MAX_HORIZON - 1);
    end else begin
      last_idx_nxt = ROW_W'(hor_len_r - 1'b1);
    end
  end

  always_comb begin
    lane_ctl.cmp_en    = (state_r == S_TICK_CMP);
    lane_ctl.mul_en    = (state_r == S_TICK_MUL);
    lane_ctl.commit    = load;
    lane_ctl.is_row    = (state_r == S_ROW);
    lane_ctl.row_first = (row_cnt_r == '0);
    lane_ctl.standing  = standing_r;
  end

  for (genvar g = 0; g < gps_pkg::NUM_LEG_PORTS; g++) begin : g_leg
    if (g < LEGS) begin : g_lane
      gps_lane u_lane (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (lane_ctl),
        .base_phase   (base_phase),
        .offset       (offsets_r[g*gps_pkg::PHASE_W +: gps_pkg::PHASE_W]),
        .duty         (duty_r),
        .stance_scale (stance_scale_r),
        .swing_scale  (swing_scale_r),
        .contact      (contact_r[g]),
        .active       (mask_r[g]),
        .emit_state   (lane_state[g]),
        .emit_phase   (lane_phase[g])
      );
    end else begin : g_absent
      assign lane_state[g] = 1'b0;
      assign lane_phase[g] = '0;
    end
  end

  always_comb begin
    row.state     = lane_state;
    row.phase     = lane_phase;
    row.row_index = (state_r == S_ROW) ? gps_pkg::ROW_IDX_W'(row_cnt_r) : '0;
    row.last      = (state_r == S_ROW) ? row_last : 1'b1;
  end

  gps_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .row       (row),
    .slot_free (slot_free),
    .out_ch    (out_ch)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_step_r    <= gps_pkg::RST_TICK_STEP;
      hor_step_r     <= gps_pkg::RST_HORIZON_STEP;
      duty_r         <= gps_pkg::RST_DUTY;
      stance_scale_r <= gps_pkg::RST_STANCE_SCALE;
      swing_scale_r  <= gps_pkg::RST_SWING_SCALE;
      offsets_r      <= gps_pkg::RST_LEG_OFFSETS;
      hor_len_r      <= gps_pkg::RST_HORIZON_LEN;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gps_pkg::CFG_TICK_STEP:    tick_step_r    <= cfg_data[gps_pkg::PHASE_W-1:0];
        gps_pkg::CFG_HORIZON_STEP: hor_step_r     <= cfg_data[gps_pkg::PHASE_W-1:0];
        gps_pkg::CFG_DUTY:         duty_r         <= cfg_data[gps_pkg::PHASE_W-1:0];
        gps_pkg::CFG_STANCE_SCALE: stance_scale_r <= cfg_data[gps_pkg::SCALE_W-1:0];
        gps_pkg::CFG_SWING_SCALE:  swing_scale_r  <= cfg_data[gps_pkg::SCALE_W-1:0];
        gps_pkg::CFG_LEG_OFFSETS:  offsets_r      <= cfg_data[gps_pkg::OFFS_W-1:0];
        gps_pkg::CFG_HORIZON_LEN:  hor_len_r      <= cfg_data[gps_pkg::HLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // input capture, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      standing_r   <= in_ch.standing;
      contact_r[0] <= in_ch.contact_leg0;
      contact_r[1] <= in_ch.contact_leg1;
      contact_r[2] <= in_ch.contact_leg2;
      contact_r[3] <= in_ch.contact_leg3;
      mask_r       <= in_ch.active_mask;
      last_idx_r   <= last_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      run_phase_r     <= '0;
      prev_standing_r <= 1'b0;
      tbl_phase_r     <= '0;
      row_cnt_r       <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            prev_standing_r <= in_ch.standing;
            if (in_ch.command == gps_pkg::CMD_TABLE) begin
              tbl_phase_r <= in_ch.start_phase;
              row_cnt_r   <= '0;
              state_r     <= S_ROW;
            end else begin
              run_phase_r <= run_start + tick_step_r;
              state_r     <= S_TICK_CMP;
            end
          end
        end
        S_TICK_CMP: state_r <= S_TICK_MUL;
        S_TICK_MUL: state_r <= S_TICK_OUT;
        S_TICK_OUT: begin
          if (slot_free) begin
            state_r <= S_IDLE;
          end
        end
        S_ROW: begin
          if (slot_free) begin
            tbl_phase_r <= tbl_phase_nxt;
            if (row_last) begin
              state_r <= S_IDLE;
            end else begin
              row_cnt_r <= row_cnt_r + 1'b1;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: bench/gait_phase_scheduler_core_test.sv
`timescale 1ns / 1ps
module gait_phase_scheduler_core_test;
  import gps_pkg::*;

  typedef struct packed {
    logic                            command;
    logic                            standing;
    logic [PHASE_W-1:0]              start_phase;
    logic [3:0][CONTACT_W-1:0]       contact;
    logic [3:0]                      active_mask;
  } gait_cmd_t;

  typedef enum logic [1:0] {STEP_ITEM, STEP_CFG} dir_kind_e;

  typedef struct packed {
    dir_kind_e             kind;
    gait_cmd_t             cmd;
    logic                  typed;
    gps_row_t              want;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
  } dir_step_t;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  gps_in_if  in_ch ();
  gps_out_if out_ch ();

  gait_phase_scheduler_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // register copies
  logic [PHASE_W-1:0]              tick_step;
  logic [PHASE_W-1:0]              horizon_step;
  logic [PHASE_W-1:0]              duty;
  logic [SCALE_W-1:0]              stance_scale;
  logic [SCALE_W-1:0]              swing_scale;
  logic [3:0][PHASE_W-1:0]         leg_offs;
  logic [HLEN_W-1:0]               horizon_len;

  // gait state
  logic [PHASE_W-1:0]              run_phase;
  logic                            stood_last;
  logic [3:0]                      tick_state;
  logic [3:0][PHASE_W-1:0]         tick_phase;
  logic [3:0]                      walk_state;
  logic [PHASE_W-1:0]              walk_phase;

  gps_row_t   pending_rows[$];
  gps_row_t   seen_row;
  gps_row_t   due_row;
  gait_cmd_t  taken_cmd;
  gait_cmd_t  next_cmd;
  logic       fixed_en;
  gps_row_t   fixed_row;
  idle_mode_e idle_mode;
  int         mismatches;
  dir_step_t  script[$];
  logic       quiet;
  logic       stand_run;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic logic [PHASE_W-1:0] scaled(logic [PHASE_W-1:0] frac,
                                                logic [SCALE_W-1:0] scale);
    logic [PROD_W-1:0] prod;
    prod = ({{SCALE_W{1'b0}}, frac} * {{PHASE_W{1'b0}}, scale}) >> PHASE_W;
    return (prod > 40'd65535) ? 16'hFFFF : prod[PHASE_W-1:0];
  endfunction

  function automatic void advance_gait(input gait_cmd_t c);
    gps_row_t          r;
    logic [PHASE_W-1:0] p;
    int                rows;
    if (c.command == CMD_TICK) begin
      if (stood_last && !c.standing) run_phase = '0;
      run_phase = run_phase + tick_step;
      r = '0;
      for (int l = 0; l < NUM_LEG_PORTS; l++) begin
        p = run_phase + leg_offs[l];
        if (c.standing) begin
          // inside stance window: pinned to stance, phase held
          if (p < duty) tick_state[l] = LEG_STANCE;
          else tick_phase[l] = scaled(p - duty, swing_scale);
        end else if (p < duty) begin
          tick_state[l] = LEG_STANCE;
          tick_phase[l] = scaled(p, stance_scale);
        end else begin
          tick_state[l] = LEG_SWING;
          tick_phase[l] = scaled(p - duty, swing_scale);
        end
        r.state[l] = tick_state[l];
        r.phase[l] = tick_phase[l];
      end
      r.last = 1'b1;
      pending_rows.push_back(r);
    end else begin
      if (horizon_len == 0) rows = 1;
      else if (horizon_len > DEF_MAX_HORIZON) rows = DEF_MAX_HORIZON;
      else rows = horizon_len;
      walk_phase = c.start_phase;
      for (int i = 0; i < rows; i++) begin
        walk_phase = walk_phase + horizon_step;
        r = '0;
        for (int l = 0; l < NUM_LEG_PORTS; l++) begin
          if (!c.active_mask[l]) begin
            r.state[l] = LEG_SWING;
          end else begin
            p = walk_phase + leg_offs[l];
            if (c.standing) begin
              if (p < duty && c.contact[l] != CONTACT_SWING) walk_state[l] = LEG_STANCE;
            end else begin
              walk_state[l] = (p < duty) ? LEG_STANCE : LEG_SWING;
            end
            if (c.contact[l] == CONTACT_EARLY) walk_state[l] = LEG_STANCE;
            if (i == 0 && c.contact[l] == CONTACT_LATE) walk_state[l] = LEG_SWING;
            r.state[l] = walk_state[l];
          end
        end
        r.row_index = ROW_IDX_W'(i);
        r.last = (i == rows - 1);
        pending_rows.push_back(r);
      end
    end
    stood_last = c.standing;
  endfunction

  // scoreboard: check the outgoing transaction first, then predict the incoming one
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen_row.state = {out_ch.state_leg3, out_ch.state_leg2, out_ch.state_leg1,
                        out_ch.state_leg0};
      seen_row.phase[0] = out_ch.phase_leg0;
      seen_row.phase[1] = out_ch.phase_leg1;
      seen_row.phase[2] = out_ch.phase_leg2;
      seen_row.phase[3] = out_ch.phase_leg3;
      seen_row.row_index = out_ch.row_index;
      seen_row.last = out_ch.last;
      if (pending_rows.size() == 0) begin
        mismatches++;
        $display("%0t: result with nothing expected, expected none got row %0d last %0d",
                 $time, seen_row.row_index, seen_row.last);
      end else begin
        due_row = pending_rows.pop_front();
        for (int l = 0; l < NUM_LEG_PORTS; l++) begin
          if (seen_row.state[l] !== due_row.state[l]) begin
            mismatches++;
            $display("%0t: leg %0d state expected %0d got %0d", $time, l,
                     due_row.state[l], seen_row.state[l]);
          end
          if (seen_row.phase[l] !== due_row.phase[l]) begin
            mismatches++;
            $display("%0t: leg %0d phase expected %h got %h", $time, l,
                     due_row.phase[l], seen_row.phase[l]);
          end
        end
        if (seen_row.row_index !== due_row.row_index) begin
          mismatches++;
          $display("%0t: row_index expected %0d got %0d", $time,
                   due_row.row_index, seen_row.row_index);
        end
        if (seen_row.last !== due_row.last) begin
          mismatches++;
          $display("%0t: last expected %0d got %0d", $time, due_row.last, seen_row.last);
        end
      end
    end
    if (rst_n && in_ch.valid && in_ch.ready) begin
      taken_cmd.command = in_ch.command;
      taken_cmd.standing = in_ch.standing;
      taken_cmd.start_phase = in_ch.start_phase;
      taken_cmd.contact = {in_ch.contact_leg3, in_ch.contact_leg2, in_ch.contact_leg1,
                           in_ch.contact_leg0};
      taken_cmd.active_mask = in_ch.active_mask;
      advance_gait(taken_cmd);
      if (fixed_en) pending_rows[pending_rows.size() - 1] = fixed_row;
    end
  end

  always @(negedge clk) begin
    case (idle_mode)
      IDLE_RECEIVER: out_ch.ready <= ($urandom_range(99) >= 68);
      IDLE_BOTH:     out_ch.ready <= ($urandom_range(99) >= 38);
      default:       out_ch.ready <= 1'b1;
    endcase
  end

  function automatic logic sender_idles();
    case (idle_mode)
      IDLE_SENDER: return $urandom_range(99) < 68;
      IDLE_BOTH:   return $urandom_range(99) < 38;
      default:     return 1'b0;
    endcase
  endfunction

  task automatic send_txn(input gait_cmd_t c, input logic typed, input gps_row_t want);
    @(negedge clk);
    while (sender_idles()) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    fixed_en = typed;
    fixed_row = want;
    in_ch.command <= c.command;
    in_ch.standing <= c.standing;
    in_ch.start_phase <= c.start_phase;
    in_ch.contact_leg0 <= c.contact[0];
    in_ch.contact_leg1 <= c.contact[1];
    in_ch.contact_leg2 <= c.contact[2];
    in_ch.contact_leg3 <= c.contact[3];
    in_ch.active_mask <= c.active_mask;
    in_ch.valid <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_rows.size() != 0) @(negedge clk);
    // leave slack before touching registers
    repeat (4) @(negedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_TICK_STEP:    tick_step = val[PHASE_W-1:0];
      CFG_HORIZON_STEP: horizon_step = val[PHASE_W-1:0];
      CFG_DUTY:         duty = val[PHASE_W-1:0];
      CFG_STANCE_SCALE: stance_scale = val[SCALE_W-1:0];
      CFG_SWING_SCALE:  swing_scale = val[SCALE_W-1:0];
      CFG_LEG_OFFSETS:  leg_offs = val;
      CFG_HORIZON_LEN:  horizon_len = val[HLEN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic retune();
    logic [PHASE_W-1:0] d;
    logic [63:0]        recip;
    case ($urandom_range(3))
      0:       set_reg(CFG_TICK_STEP, 64'($urandom_range(1, 2000)));
      1:       set_reg(CFG_TICK_STEP, $urandom_range(1) ? 64'hFFFF : 64'h0);
      default: set_reg(CFG_TICK_STEP, 64'($urandom_range(65535)));
    endcase
    set_reg(CFG_HORIZON_STEP, 64'($urandom_range(65535)));
    case ($urandom_range(7))
      0:       d = 16'h0000;
      1:       d = 16'hFFFF;
      default: d = 16'($urandom_range(16'h2000, 16'hE000));
    endcase
    set_reg(CFG_DUTY, 64'(d));
    if ($urandom_range(3) != 0) begin
      recip = (d == 0) ? 64'hFFFFFF : (64'h1_0000_0000 / d);
      set_reg(CFG_STANCE_SCALE, (recip > 64'hFFFFFF) ? 64'hFFFFFF : recip);
      recip = 64'h1_0000_0000 / (64'h1_0000 - d);
      set_reg(CFG_SWING_SCALE, (recip > 64'hFFFFFF) ? 64'hFFFFFF : recip);
    end else begin
      set_reg(CFG_STANCE_SCALE, 64'($urandom_range(24'hFFFFFF)));
      set_reg(CFG_SWING_SCALE, 64'($urandom_range(24'hFFFFFF)));
    end
    case ($urandom_range(3))
      0:       set_reg(CFG_LEG_OFFSETS, 64'h0000_8000_8000_0000);  // trot
      1:       set_reg(CFG_LEG_OFFSETS, 64'hC000_4000_8000_0000);  // walk
      2:       set_reg(CFG_LEG_OFFSETS, 64'h0);
      default: set_reg(CFG_LEG_OFFSETS, {$urandom, $urandom});
    endcase
    case ($urandom_range(9))
      0:       set_reg(CFG_HORIZON_LEN, 64'd0);
      1:       set_reg(CFG_HORIZON_LEN, 64'd64);
      2:       set_reg(CFG_HORIZON_LEN, 64'd127);
      3:       set_reg(CFG_HORIZON_LEN, 64'($urandom_range(13, 63)));
      default: set_reg(CFG_HORIZON_LEN, 64'($urandom_range(1, 12)));
    endcase
  endtask

  function automatic gait_cmd_t draw_cmd(input logic stand);
    gait_cmd_t c;
    c.command = ($urandom_range(99) < 62) ? CMD_TICK : CMD_TABLE;
    c.standing = stand;
    c.start_phase = 16'($urandom_range(65535));
    c.contact = 8'($urandom_range(255));
    c.active_mask = ($urandom_range(1)) ? 4'hF : 4'($urandom_range(15));
    return c;
  endfunction

  function automatic gps_row_t flat_row(input logic [3:0] st, input logic [PHASE_W-1:0] ph);
    gps_row_t r;
    r = '0;
    r.state = st;
    for (int l = 0; l < NUM_LEG_PORTS; l++) r.phase[l] = ph;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic dir_step_t dir_tick(input logic stand, input logic typed,
                                         input gps_row_t want);
    dir_step_t s;
    s = '0;
    s.kind = STEP_ITEM;
    s.cmd.command = CMD_TICK;
    s.cmd.standing = stand;
    s.cmd.start_phase = 16'hFFFF;
    s.cmd.contact = {CONTACT_LATE, CONTACT_EARLY, CONTACT_SWING, CONTACT_STANCE};
    s.cmd.active_mask = 4'hF;
    s.typed = typed;
    s.want = want;
    return s;
  endfunction

  function automatic dir_step_t dir_walk(input logic stand, input logic [PHASE_W-1:0] start,
                                         input logic [3:0] mask,
                                         input logic [3:0][CONTACT_W-1:0] contact);
    dir_step_t s;
    s = '0;
    s.kind = STEP_ITEM;
    s.cmd.command = CMD_TABLE;
    s.cmd.standing = stand;
    s.cmd.start_phase = start;
    s.cmd.contact = contact;
    s.cmd.active_mask = mask;
    return s;
  endfunction

  function automatic dir_step_t dir_reg(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] val);
    dir_step_t s;
    s = '0;
    s.kind = STEP_CFG;
    s.reg_idx = idx;
    s.reg_val = val;
    return s;
  endfunction

  initial begin
    #20000000;
    $display("status: fail");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.command = CMD_TICK;
    in_ch.standing = 1'b0;
    in_ch.start_phase = '0;
    in_ch.contact_leg0 = CONTACT_STANCE;
    in_ch.contact_leg1 = CONTACT_STANCE;
    in_ch.contact_leg2 = CONTACT_STANCE;
    in_ch.contact_leg3 = CONTACT_STANCE;
    in_ch.active_mask = '0;
    out_ch.ready = 1'b0;
    idle_mode = IDLE_NONE;
    mismatches = 0;
    fixed_en = 1'b0;
    fixed_row = '0;

    tick_step = RST_TICK_STEP;
    horizon_step = RST_HORIZON_STEP;
    duty = RST_DUTY;
    stance_scale = RST_STANCE_SCALE;
    swing_scale = RST_SWING_SCALE;
    leg_offs = RST_LEG_OFFSETS;
    horizon_len = RST_HORIZON_LEN;
    run_phase = '0;
    stood_last = 1'b0;
    tick_state = '0;
    tick_phase = '0;
    walk_state = '0;
    walk_phase = '0;

    // defaults: 66 per tick, duty one half, scale 2.0
    script.push_back(dir_tick(1'b0, 1'b1, flat_row(4'b0000, 16'd132)));
    script.push_back(dir_tick(1'b0, 1'b1, flat_row(4'b0000, 16'd264)));
    script.push_back(dir_tick(1'b1, 1'b0, '0));
    // leaving stand restarts the running phase
    script.push_back(dir_tick(1'b0, 1'b1, flat_row(4'b0000, 16'd132)));
    script.push_back(dir_walk(1'b0, 16'h0000, 4'hF, {4{CONTACT_STANCE}}));
    script.push_back(dir_walk(1'b1, 16'hFFFF, 4'h0, {4{CONTACT_LATE}}));
    script.push_back(dir_walk(1'b1, 16'h8000, 4'hF,
                              {CONTACT_LATE, CONTACT_EARLY, CONTACT_SWING, CONTACT_STANCE}));
    script.push_back(dir_walk(1'b0, 16'h4000, 4'h5,
                              {CONTACT_LATE, CONTACT_LATE, CONTACT_EARLY, CONTACT_EARLY}));
    // zero duty, saturating scales, full steps, length 0 acts as one row
    script.push_back(dir_reg(CFG_LEG_OFFSETS, 64'hC000_8000_4000_0000));
    script.push_back(dir_reg(CFG_DUTY, 64'h0));
    script.push_back(dir_reg(CFG_STANCE_SCALE, 64'hFFFFFF));
    script.push_back(dir_reg(CFG_SWING_SCALE, 64'hFFFFFF));
    script.push_back(dir_reg(CFG_TICK_STEP, 64'hFFFF));
    script.push_back(dir_reg(CFG_HORIZON_STEP, 64'hFFFF));
    script.push_back(dir_reg(CFG_HORIZON_LEN, 64'd0));
    script.push_back(dir_tick(1'b0, 1'b0, '0));
    script.push_back(dir_tick(1'b1, 1'b0, '0));
    script.push_back(dir_walk(1'b0, 16'h1234, 4'hF, {4{CONTACT_LATE}}));
    script.push_back(dir_walk(1'b1, 16'hFFFF, 4'hA, {4{CONTACT_SWING}}));
    // full duty, zero scales and steps, oversize length clamps to 64
    script.push_back(dir_reg(CFG_DUTY, 64'hFFFF));
    script.push_back(dir_reg(CFG_STANCE_SCALE, 64'h0));
    script.push_back(dir_reg(CFG_SWING_SCALE, 64'h0));
    script.push_back(dir_reg(CFG_TICK_STEP, 64'h0));
    script.push_back(dir_reg(CFG_HORIZON_STEP, 64'h0));
    script.push_back(dir_reg(CFG_HORIZON_LEN, 64'd127));
    script.push_back(dir_tick(1'b0, 1'b0, '0));
    script.push_back(dir_tick(1'b1, 1'b0, '0));
    script.push_back(dir_walk(1'b0, 16'h0000, 4'hF, {4{CONTACT_EARLY}}));
    script.push_back(dir_walk(1'b1, 16'hFFFF, 4'hF,
                              {CONTACT_STANCE, CONTACT_SWING, CONTACT_EARLY, CONTACT_LATE}));
    script.push_back(dir_reg(CFG_HORIZON_LEN, 64'd64));
    script.push_back(dir_reg(CFG_HORIZON_STEP, 64'd1024));
    script.push_back(dir_reg(CFG_DUTY, 64'h8000));
    script.push_back(dir_reg(CFG_STANCE_SCALE, 64'h20000));
    script.push_back(dir_reg(CFG_SWING_SCALE, 64'h20000));
    script.push_back(dir_reg(CFG_LEG_OFFSETS, 64'hFFFF_FFFF_FFFF_FFFF));
    script.push_back(dir_reg(CFG_TICK_STEP, 64'h8000));
    script.push_back(dir_walk(1'b1, 16'h7FFF, 4'hF,
                              {CONTACT_SWING, CONTACT_STANCE, CONTACT_LATE, CONTACT_EARLY}));
    script.push_back(dir_tick(1'b0, 1'b0, '0));
    script.push_back(dir_tick(1'b1, 1'b0, '0));
    script.push_back(dir_tick(1'b0, 1'b0, '0));
    script.push_back(dir_reg(CFG_HORIZON_LEN, 64'd1));
    script.push_back(dir_reg(CFG_LEG_OFFSETS, 64'h0000_8000_8000_0000));
    script.push_back(dir_reg(CFG_TICK_STEP, 64'd1311));
    script.push_back(dir_reg(CFG_DUTY, 64'hA000));
    script.push_back(dir_reg(CFG_STANCE_SCALE, 64'h19999));
    script.push_back(dir_reg(CFG_SWING_SCALE, 64'h2AAAA));
    script.push_back(dir_walk(1'b0, 16'h0100, 4'hF, {4{CONTACT_STANCE}}));
    script.push_back(dir_tick(1'b0, 1'b0, '0));

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    quiet = 1'b1;
    foreach (script[k]) begin
      if (script[k].kind == STEP_CFG) begin
        if (!quiet) begin
          drain();
          quiet = 1'b1;
        end
        set_reg(script[k].reg_idx, script[k].reg_val);
      end else begin
        quiet = 1'b0;
        send_txn(script[k].cmd, script[k].typed, script[k].want);
      end
    end

    stand_run = 1'b0;
    for (int seg = 0; seg < 8; seg++) begin
      drain();
      idle_mode = IDLE_NONE;
      retune();
      idle_mode = idle_mode_e'(seg % 4);
      for (int n = 0; n < 50; n++) begin
        // standing comes in runs so hold and restart behavior gets exercised
        if ($urandom_range(99) < 12) stand_run = ~stand_run;
        next_cmd = draw_cmd(stand_run);
        send_txn(next_cmd, 1'b0, '0);
      end
    end

    drain();
    repeat (8) @(negedge clk);
    if (mismatches == 0 && pending_rows.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
